// ----- rtl/core/ids_pkg.sv -----
// Shared types, character codes and keyword table for the include directive scanner.
package ids_pkg;

    localparam int OFFSET_OUT_W = 32;
    localparam int LENGTH_OUT_W = 16;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_LT    = 8'h3C;
    localparam logic [7:0] CH_GT    = 8'h3E;

    localparam logic [2:0] KW_LEN = 3'd7;

    typedef enum logic [5:0] {
        PH_LEAD = 6'b000001,
        PH_HASH = 6'b000010,
        PH_WORD = 6'b000100,
        PH_GAP  = 6'b001000,
        PH_NAME = 6'b010000,
        PH_SKIP = 6'b100000
    } ids_phase_t;

    typedef struct packed {
        logic [OFFSET_OUT_W-1:0] name_offset;
        logic [LENGTH_OUT_W-1:0] name_length;
        logic                    system_header;
    } ids_result_t;

    typedef struct packed {
        logic        push;
        ids_result_t data;
    } ids_push_t;

    function automatic logic [7:0] kw_char(input logic [2:0] idx);
        logic [7:0] c;
        case (idx)
            3'd0:    c = 8'h69; // i
            3'd1:    c = 8'h6E; // n
            3'd2:    c = 8'h63; // c
            3'd3:    c = 8'h6C; // l
            3'd4:    c = 8'h75; // u
            3'd5:    c = 8'h64; // d
            3'd6:    c = 8'h65; // e
            default: c = CH_NUL;
        endcase
        return c;
    endfunction

    function automatic logic is_blank(input logic [7:0] b);
        return (b == CH_SPACE) || (b == CH_TAB);
    endfunction

endpackage

// ----- rtl/core/ids_out_buf.sv -----
// Two-entry result buffer: output register plus a skid slot.
module ids_out_buf
    import ids_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  ids_push_t   wr,
    output logic        full,
    output logic        out_valid,
    input  logic        out_stall,
    output ids_result_t out_data
);

    logic        out_valid_reg;
    logic        out_valid_next;
    logic        skid_valid_reg;
    logic        skid_valid_next;
    ids_result_t out_data_reg;
    ids_result_t out_data_next;
    ids_result_t skid_data_reg;
    ids_result_t skid_data_next;
    logic        take;

    assign take = out_valid_reg && !out_stall;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_data_next   = out_data_reg;
        skid_data_next  = skid_data_reg;
        if (out_valid_reg && !take)
        begin
            // hold the output; park a new item in the skid slot
            if (wr.push)
            begin
                skid_valid_next = 1'b1;
                skid_data_next  = wr.data;
            end
        end
        else if (skid_valid_reg)
        begin
            // no push can arrive while the skid slot is full
            out_valid_next  = 1'b1;
            out_data_next   = skid_data_reg;
            skid_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = wr.push;
            out_data_next  = wr.data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign full      = skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

// ----- rtl/core/include_directive_scanner.sv -----
// Output: a result is written into the output buffer when its closing byte is accepted.
// Throughput: one byte per cycle while in_stall is low; the per-byte phase step is a single registered update.
// A two-entry output buffer keeps input flowing while one result waits downstream.
// Reset: rst_n clears the phase, keyword index, byte offset and buffer valid bits.
// start_of_file restarts the phase and offset on the byte that carries it.
module include_directive_scanner
    import ids_pkg::*;
#(
    parameter int OFFSET_BITS   = 32,
    parameter int NAME_LEN_BITS = 16
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_stall,
    input  logic [7:0]              data_byte,
    input  logic                    start_of_file,
    output logic                    out_valid,
    input  logic                    out_stall,
    output logic [OFFSET_OUT_W-1:0] name_offset,
    output logic [LENGTH_OUT_W-1:0] name_length,
    output logic                    system_header
);

    ids_phase_t               phase_reg;
    ids_phase_t               phase_next;
    ids_phase_t               phase_cur;
    logic [2:0]               kw_reg;
    logic [2:0]               kw_next;
    logic [2:0]               kw_cur;
    logic [OFFSET_BITS-1:0]   offset_reg;
    logic [OFFSET_BITS-1:0]   offset_next;
    logic [OFFSET_BITS-1:0]   offset_cur;
    logic [OFFSET_BITS-1:0]   name_start_reg;
    logic [OFFSET_BITS-1:0]   name_start_next;
    logic [NAME_LEN_BITS-1:0] name_count_reg;
    logic [NAME_LEN_BITS-1:0] name_count_next;
    logic                     angle_reg;
    logic                     angle_next;
    logic                     emit;
    logic                     in_accept;
    logic                     buf_full;
    logic [OFFSET_OUT_W-1:0]  offset_out;
    logic [LENGTH_OUT_W-1:0]  length_out;
    ids_push_t                wr;
    ids_result_t              out_data;

    assign in_accept = in_valid && !in_stall;
    assign in_stall  = buf_full;

    always_comb
    begin
        phase_cur  = start_of_file ? PH_LEAD : phase_reg;
        kw_cur     = start_of_file ? 3'd0 : kw_reg;
        offset_cur = start_of_file ? '0 : offset_reg;

        phase_next      = phase_cur;
        kw_next         = kw_cur;
        name_start_next = name_start_reg;
        name_count_next = name_count_reg;
        angle_next      = angle_reg;
        emit            = 1'b0;
        offset_next     = (offset_cur == '1) ? offset_cur : offset_cur + 1'b1;

        if (data_byte == CH_LF || data_byte == CH_CR)
        begin
            phase_next = PH_LEAD;
            kw_next    = 3'd0;
        end
        else if (data_byte == CH_NUL)
        begin
            phase_next = PH_SKIP;
        end
        else
        begin
            case (phase_cur)
                PH_LEAD:
                begin
                    if (data_byte == CH_HASH)
                        phase_next = PH_HASH;
                    else if (!is_blank(data_byte))
                        phase_next = PH_SKIP;
                end
                PH_HASH:
                begin
                    if (!is_blank(data_byte))
                    begin
                        if (data_byte == kw_char(3'd0))
                        begin
                            kw_next    = 3'd1;
                            phase_next = PH_WORD;
                        end
                        else
                            phase_next = PH_SKIP;
                    end
                end
                PH_WORD:
                begin
                    if (kw_cur < KW_LEN && data_byte == kw_char(kw_cur))
                    begin
                        kw_next = kw_cur + 3'd1;
                        if (kw_cur + 3'd1 == KW_LEN)
                            phase_next = PH_GAP;
                    end
                    else
                        phase_next = PH_SKIP;
                end
                PH_GAP:
                begin
                    if (!is_blank(data_byte))
                    begin
                        if (data_byte == CH_LT || data_byte == CH_QUOTE)
                        begin
                            angle_next      = (data_byte == CH_LT);
                            name_start_next = offset_next;
                            name_count_next = '0;
                            phase_next      = PH_NAME;
                        end
                        else
                            phase_next = PH_SKIP;
                    end
                end
                PH_NAME:
                begin
                    if (data_byte == CH_GT || data_byte == CH_QUOTE)
                    begin
                        emit       = 1'b1;
                        phase_next = PH_SKIP;
                    end
                    else if (name_count_reg != '1)
                        name_count_next = name_count_reg + 1'b1;
                end
                default:
                begin
                    phase_next = PH_SKIP;
                end
            endcase
        end
    end

    // clamp the internal counters to the output field widths
    generate
        if (OFFSET_BITS > OFFSET_OUT_W)
        begin : g_off_sat
            assign offset_out = (|name_start_reg[OFFSET_BITS-1:OFFSET_OUT_W]) ? '1
                              : name_start_reg[OFFSET_OUT_W-1:0];
        end
        else
        begin : g_off_ext
            assign offset_out = OFFSET_OUT_W'(name_start_reg);
        end
        if (NAME_LEN_BITS > LENGTH_OUT_W)
        begin : g_len_sat
            assign length_out = (|name_count_reg[NAME_LEN_BITS-1:LENGTH_OUT_W]) ? '1
                              : name_count_reg[LENGTH_OUT_W-1:0];
        end
        else
        begin : g_len_ext
            assign length_out = LENGTH_OUT_W'(name_count_reg);
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_LEAD;
            kw_reg     <= 3'd0;
            offset_reg <= '0;
        end
        else if (in_accept)
        begin
            phase_reg  <= phase_next;
            kw_reg     <= kw_next;
            offset_reg <= offset_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            name_start_reg <= name_start_next;
            name_count_reg <= name_count_next;
            angle_reg      <= angle_next;
        end
    end

    assign wr.push              = in_accept && emit;
    assign wr.data.name_offset  = offset_out;
    assign wr.data.name_length  = length_out;
    assign wr.data.system_header = angle_reg;

    ids_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr        (wr),
        .full      (buf_full),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    assign name_offset   = out_data.name_offset;
    assign name_length   = out_data.name_length;
    assign system_header = out_data.system_header;

    a_skid_implies_out: assert property (@(posedge clk) disable iff (!rst_n)
        buf_full |-> out_valid)
        else $error("skid slot full while output register empty");

    a_close_skips: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && emit) |=> (phase_reg == PH_SKIP))
        else $error("closing byte did not move scanner to skip phase");

    a_offset_moves: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> (offset_reg != '0))
        else $error("byte offset zero after an accepted item");

endmodule
